>>> sv/fhrs_pkg.sv
// Package for the firmware hash region scanner.
// Holds the marker tags, result kind codes, scan mode type and result record type.
// No dependencies.
`timescale 1ns / 1ps

package fhrs_pkg;

  localparam int TAG_LEN     = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int OFFSET_BITS = 24;

  localparam logic [7:0] HEAD_TAG [TAG_LEN] = '{"T", "C", "P", "A", "C", "P", "U", "H"};
  localparam logic [7:0] TAIL_TAG [TAG_LEN] = '{"I", "B", "M", "S", "E", "C", "U", "R"};

  localparam logic [1:0] KIND_RECORD    = 2'd0;
  localparam logic [1:0] KIND_SUMMARY   = 2'd1;
  localparam logic [1:0] KIND_EMPTY     = 2'd2;
  localparam logic [1:0] KIND_NOT_FOUND = 2'd3;

  typedef enum logic [2:0] {
    MODE_SEARCH  = 3'b001,
    MODE_RECORDS = 3'b010,
    MODE_DONE    = 3'b100
  } mode_t;

  typedef struct packed {
    logic [1:0]             kind;
    logic [7:0]             record_index;
    logic [OFFSET_BITS-1:0] record_offset;
    logic [31:0]            cpuid;
    logic [OFFSET_BITS-1:0] region_offset;
    logic [OFFSET_BITS-1:0] region_length;
    logic [8:0]             record_count;
    logic                   last_result;
  } result_t;

endpackage

>>> sv/firmware_hash_region_scanner.sv
// Top level of the firmware hash region scanner: marker window, record walker, result queue.
// Depends on fhrs_pkg.
`timescale 1ns / 1ps

// Usage:
//   Input channel (in_valid / in_stall, data_byte, last_byte) carries one image byte
//   per transaction; last_byte marks the final byte of an image.
//   Output channel (out_valid / out_stall, kind ... last_result) carries one result
//   per transaction; last_result marks the final result caused by one input byte.
//   A byte is examined at the edge it is accepted and its zero, one or two results
//   enter a four-entry result queue at that edge; the output shows the registered
//   head of the queue. Throughput is one byte per cycle while in_stall is low.
//   Only the final byte of an image can cause two
//   results. in_stall rises while the queue holds three or more results, so the
//   queue always has room for the two results of the next byte.
//   When the receiver stalls, the head result holds and the queue fills until the
//   input side stalls in turn.
//   Reset clears the window, counters and the queue; the next byte starts an image.
//   After a final byte the scanner returns to its reset state by itself.
module firmware_hash_region_scanner #(
  parameter int RECORD_BYTES = 163,
  parameter int GAP_BYTES    = 13,
  parameter int ID_OFFSET    = 27,
  parameter int ADDR_BITS    = 24
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  kind,
  output logic [7:0]  record_index,
  output logic [23:0] record_offset,
  output logic [31:0] cpuid,
  output logic [23:0] region_offset,
  output logic [23:0] region_length,
  output logic [8:0]  record_count,
  output logic        last_result
);

  localparam int WinLen    = 2 * fhrs_pkg::TAG_LEN + GAP_BYTES;
  localparam int EmitPoint = (ID_OFFSET + 3 > RECORD_BYTES - 1) ? RECORD_BYTES - 1
                                                                : ID_OFFSET + 3;
  localparam int PtrW      = $clog2(fhrs_pkg::QUEUE_DEPTH);
  localparam int CountW    = $clog2(fhrs_pkg::QUEUE_DEPTH + 1);

  logic [7:0]           window [WinLen];
  logic [ADDR_BITS-1:0] byte_position;
  fhrs_pkg::mode_t      mode, mode_next;
  logic [8:0]           record_number, record_number_next;
  logic [7:0]           byte_in_record, byte_in_record_next;
  logic [31:0]          id_word, id_word_next;
  logic [ADDR_BITS-1:0] region_start, region_start_next;
  logic [ADDR_BITS-1:0] record_start, record_start_next;

  fhrs_pkg::result_t    queue [fhrs_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0]      wr_ptr, rd_ptr, wr_ptr_plus1;
  logic [CountW-1:0]    count;

  logic                 in_fire, out_fire, marker_hit;
  logic                 main_v, trec_v, tsum_v, res0_v, res1_v;
  fhrs_pkg::result_t    main_res, trec_res, tsum_res, res0, res1;

  function automatic logic [23:0] to_offset(input logic [ADDR_BITS-1:0] a);
    logic [31:0] w;
    w = 32'(a);
    return w[23:0];
  endfunction

  function automatic fhrs_pkg::result_t make_summary(input logic [8:0] cnt,
                                                     input logic [23:0] start);
    fhrs_pkg::result_t r;
    logic [16:0] len;
    r = '0;
    len = cnt * 8'(RECORD_BYTES);
    r.region_offset = start;
    if (cnt != 9'd0) begin
      r.kind          = fhrs_pkg::KIND_SUMMARY;
      r.region_length = 24'(len);
      r.record_count  = cnt;
    end else begin
      r.kind = fhrs_pkg::KIND_EMPTY;
    end
    return r;
  endfunction

  function automatic fhrs_pkg::result_t make_record(input logic [8:0] num,
                                                    input logic [23:0] start,
                                                    input logic [31:0] word);
    fhrs_pkg::result_t r;
    logic [8:0] idx;
    r = '0;
    idx = num - 9'd1;
    r.kind          = fhrs_pkg::KIND_RECORD;
    r.record_index  = idx[7:0];
    r.record_offset = start;
    r.cpuid         = word;
    return r;
  endfunction

  assign in_fire   = in_valid & ~in_stall;
  assign out_fire  = out_valid & ~out_stall;
  assign in_stall  = count > CountW'(fhrs_pkg::QUEUE_DEPTH - 2);
  assign out_valid = count != '0;

  always_comb begin
    marker_hit = 1'b1;
    for (int k = 0; k < fhrs_pkg::TAG_LEN; k++) begin
      if (window[1 + k] != fhrs_pkg::HEAD_TAG[k]) begin
        marker_hit = 1'b0;
      end
    end
    for (int k = 0; k < fhrs_pkg::TAG_LEN - 1; k++) begin
      if (window[WinLen - fhrs_pkg::TAG_LEN + 1 + k] != fhrs_pkg::TAIL_TAG[k]) begin
        marker_hit = 1'b0;
      end
    end
    if (data_byte != fhrs_pkg::TAIL_TAG[fhrs_pkg::TAG_LEN - 1]) begin
      marker_hit = 1'b0;
    end
  end

  always_comb begin
    mode_next           = mode;
    record_number_next  = record_number;
    byte_in_record_next = byte_in_record;
    id_word_next        = id_word;
    region_start_next   = region_start;
    record_start_next   = record_start;
    main_v              = 1'b0;
    main_res            = '0;
    trec_v              = 1'b0;
    trec_res            = '0;
    tsum_v              = 1'b0;
    tsum_res            = '0;

    case (mode)
      fhrs_pkg::MODE_SEARCH: begin
        if (marker_hit) begin
          mode_next           = fhrs_pkg::MODE_RECORDS;
          region_start_next   = byte_position + 1'b1;
          record_number_next  = '0;
          byte_in_record_next = '0;
          id_word_next        = '0;
        end
      end
      fhrs_pkg::MODE_RECORDS: begin
        if (byte_in_record == 8'd0 &&
            !(record_number < 9'd256 && {1'b0, data_byte} == record_number)) begin
          main_v    = 1'b1;
          main_res  = make_summary(record_number, to_offset(region_start));
          mode_next = fhrs_pkg::MODE_DONE;
        end else begin
          if (byte_in_record == 8'd0) begin
            record_number_next = record_number + 9'd1;
            record_start_next  = byte_position;
            id_word_next       = '0;
          end
          for (int k = 0; k < 4; k++) begin
            if ({1'b0, byte_in_record} == 9'(ID_OFFSET + k)) begin
              id_word_next[8*k +: 8] = data_byte;
            end
          end
          if (byte_in_record == 8'(EmitPoint)) begin
            main_v   = 1'b1;
            main_res = make_record(record_number_next, to_offset(record_start_next),
                                   id_word_next);
          end
          if (byte_in_record == 8'(RECORD_BYTES - 1)) begin
            byte_in_record_next = '0;
          end else begin
            byte_in_record_next = byte_in_record + 8'd1;
          end
        end
      end
      fhrs_pkg::MODE_DONE: begin
      end
      default: begin
      end
    endcase

    if (last_byte) begin
      if (mode_next == fhrs_pkg::MODE_SEARCH) begin
        tsum_v        = 1'b1;
        tsum_res.kind = fhrs_pkg::KIND_NOT_FOUND;
      end else if (mode_next == fhrs_pkg::MODE_RECORDS) begin
        if (byte_in_record_next != 8'd0 && byte_in_record_next <= 8'(EmitPoint)) begin
          trec_v   = 1'b1;
          trec_res = make_record(record_number_next, to_offset(record_start_next),
                                 id_word_next);
        end
        tsum_v   = 1'b1;
        tsum_res = make_summary(record_number_next, to_offset(region_start_next));
      end
    end

    res0_v = main_v | trec_v | tsum_v;
    res1_v = (main_v | trec_v) & tsum_v;
    res0   = main_v ? main_res : (trec_v ? trec_res : tsum_res);
    res1   = tsum_res;
    res0.last_result = ~res1_v;
    res1.last_result = 1'b1;
  end

  assign wr_ptr_plus1 = wr_ptr + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WinLen; i++) begin
        window[i] <= '0;
      end
      byte_position  <= '0;
      mode           <= fhrs_pkg::MODE_SEARCH;
      record_number  <= '0;
      byte_in_record <= '0;
      id_word        <= '0;
      region_start   <= '0;
      record_start   <= '0;
    end else if (in_fire) begin
      if (last_byte) begin
        for (int i = 0; i < WinLen; i++) begin
          window[i] <= '0;
        end
        byte_position  <= '0;
        mode           <= fhrs_pkg::MODE_SEARCH;
        record_number  <= '0;
        byte_in_record <= '0;
        id_word        <= '0;
        region_start   <= '0;
        record_start   <= '0;
      end else begin
        if (mode == fhrs_pkg::MODE_SEARCH) begin
          for (int i = 0; i < WinLen - 1; i++) begin
            window[i] <= window[i + 1];
          end
          window[WinLen - 1] <= data_byte;
        end
        byte_position  <= byte_position + 1'b1;
        mode           <= mode_next;
        record_number  <= record_number_next;
        byte_in_record <= byte_in_record_next;
        id_word        <= id_word_next;
        region_start   <= region_start_next;
        record_start   <= record_start_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res0_v) begin
      queue[wr_ptr] <= res0;
    end
    if (in_fire && res1_v) begin
      queue[wr_ptr_plus1] <= res1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (in_fire) begin
        wr_ptr <= wr_ptr + PtrW'({res1_v, res0_v & ~res1_v});
      end
      if (out_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CountW'(in_fire ? {res1_v, res0_v & ~res1_v} : 2'd0)
                     - CountW'(out_fire);
    end
  end

  assign kind          = queue[rd_ptr].kind;
  assign record_index  = queue[rd_ptr].record_index;
  assign record_offset = queue[rd_ptr].record_offset;
  assign cpuid         = queue[rd_ptr].cpuid;
  assign region_offset = queue[rd_ptr].region_offset;
  assign region_length = queue[rd_ptr].region_length;
  assign record_count  = queue[rd_ptr].record_count;
  assign last_result   = queue[rd_ptr].last_result;

`ifndef SYNTHESIS
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CountW'(fhrs_pkg::QUEUE_DEPTH))
    else $error("result queue overflow");

  a_image_end_resets: assert property (@(posedge clk) disable iff (rst)
    in_fire && last_byte |=> mode == fhrs_pkg::MODE_SEARCH && byte_position == '0)
    else $error("scanner state not cleared after final byte");

  a_record_limit: assert property (@(posedge clk) disable iff (rst)
    record_number <= 9'd256 && byte_in_record < 8'(RECORD_BYTES))
    else $error("record counters out of range");

  a_stall_room: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> count <= CountW'(fhrs_pkg::QUEUE_DEPTH - 2))
    else $error("input open without room for two results");
`endif

endmodule
